@@ hw/rtl/partition_lba_to_chs_translator_macros.svh @@
// Assertion macros shared by the translator RTL.
`ifndef PARTITION_LBA_TO_CHS_TRANSLATOR_MACROS_SVH
`define PARTITION_LBA_TO_CHS_TRANSLATOR_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PLCT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PLCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/plct_pkg.sv @@
// Shared types, codes and sizes of the partition block-to-CHS translator.
`timescale 1ns / 1ps
package plct_pkg;

  localparam int DISK_COUNT_DEF    = 4;
  localparam int TABLE_ENTRIES_DEF = 32;

  localparam int MINOR_W        = 8;
  localparam int PARTS_PER_DISK = 8;
  localparam int PART_SHIFT     = $clog2(PARTS_PER_DISK);
  localparam int UNIT_W         = MINOR_W - PART_SHIFT;
  localparam int PART_IDX_W     = 5;
  localparam int IDX_W          = 5;

  localparam int ABS_W      = 32;
  localparam int SEC_W      = 8;
  localparam int HEAD_W     = 5;
  localparam int HEAD_OUT_W = 4;
  localparam int CYL_W      = 16;
  localparam int CMD_W      = 8;

  localparam logic [HEAD_W-1:0] MAX_HEADS = HEAD_W'(16);

  localparam int FIFO_DEPTH  = 4;
  localparam int DIV_BITS    = 4;
  localparam int DIV_STAGES  = ABS_W / DIV_BITS;
  localparam int PIPE_STAGES = 2 * DIV_STAGES;

  localparam logic [1:0] OP_TRANSLATE  = 2'd0;
  localparam logic [1:0] OP_PART_WRITE = 2'd1;
  localparam logic [1:0] OP_GEO_WRITE  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_NODEV = 2'd2;
  localparam logic [1:0] ST_IO    = 2'd3;

  localparam logic [CMD_W-1:0] CMD_RD = 8'h20;
  localparam logic [CMD_W-1:0] CMD_WR = 8'h30;

  // Classified request handed from the front end to the divider back end.
  typedef struct packed {
    logic              go;
    logic [1:0]        status;
    logic [ABS_W-1:0]  abs_blk;
    logic [SEC_W-1:0]  secs;
    logic [HEAD_W-1:0] heads;
    logic [CYL_W-1:0]  cyl;
    logic [1:0]        unit_lo;
    logic              is_write;
  } beat_t;

endpackage

@@ hw/rtl/plct_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module plct_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/plct_front.sv @@
// Front end: accepts requests, owns the partition and geometry tables, classifies errors.
`timescale 1ns / 1ps
module plct_front import plct_pkg::*; #(
  parameter int DISK_COUNT    = DISK_COUNT_DEF,
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         operation,
  input  logic [MINOR_W-1:0] minor_number,
  input  logic [ABS_W-1:0]   block_number,
  input  logic               is_write,
  input  logic [IDX_W-1:0]   table_index,
  input  logic [ABS_W-1:0]   entry_offset,
  input  logic [ABS_W-1:0]   entry_size,
  input  logic [SEC_W-1:0]   geo_sectors,
  input  logic [HEAD_W-1:0]  geo_heads,
  input  logic [CYL_W-1:0]   geo_cylinders,
  output logic               push,
  output beat_t              push_beat,
  input  logic               q_full
);

  localparam int TE_AW    = $clog2(TABLE_ENTRIES);
  localparam int TE_SLOTS = 2 ** TE_AW;
  localparam int DW       = (DISK_COUNT > 1) ? $clog2(DISK_COUNT) : 1;

  logic              accept;
  logic              a_valid;
  logic [1:0]        a_op;
  logic [ABS_W-1:0]  a_blk;
  logic              a_is_write;
  logic [UNIT_W-1:0] a_unit;
  logic              a_unit_ok;
  logic              a_prange;
  logic              a_pvalid;
  logic [SEC_W-1:0]  a_secs;
  logic [HEAD_W-1:0] a_heads;
  logic [CYL_W-1:0]  a_cyl;

  logic [TE_SLOTS-1:0] pvalid;
  logic [SEC_W-1:0]    geo_secs  [DISK_COUNT];
  logic [HEAD_W-1:0]   geo_hds   [DISK_COUNT];
  logic [CYL_W-1:0]    geo_cyls  [DISK_COUNT];

  logic [5:0]         ridx;
  logic [5:0]         widx;
  logic [UNIT_W-1:0]  unit;
  logic               unit_ok;
  logic [DW-1:0]      unit_sel;
  logic [DW-1:0]      geo_idx;
  logic               part_wr;
  logic               geo_wr;
  logic               geo_absent;
  logic [HEAD_W-1:0]  h_clamp;
  logic [2*ABS_W-1:0] rdata;
  logic [ABS_W-1:0]   psize;
  logic [ABS_W-1:0]   poff;
  logic [ABS_W:0]     sum;

  assign req_stall = a_valid && q_full;
  assign accept    = req_valid && !req_stall;
  assign push      = a_valid && !q_full;

  assign ridx     = {1'b0, minor_number[PART_IDX_W-1:0]};
  assign widx     = {1'b0, table_index};
  assign unit     = minor_number[MINOR_W-1:PART_SHIFT];
  assign unit_ok  = unit < UNIT_W'(DISK_COUNT);
  assign unit_sel = unit[DW-1:0];
  assign geo_idx  = table_index[DW-1:0];

  assign part_wr = accept && (operation == OP_PART_WRITE) &&
                   (7'(table_index) < 7'(TABLE_ENTRIES));
  assign geo_wr  = accept && (operation == OP_GEO_WRITE) &&
                   (6'(table_index) < 6'(DISK_COUNT));

  assign h_clamp    = (geo_heads > MAX_HEADS) ? MAX_HEADS : geo_heads;
  assign geo_absent = (geo_sectors == '0) || (geo_heads == '0) || (geo_cylinders == '0);

  plct_ram #(
    .WIDTH (2 * ABS_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_part_ram (
    .clk   (clk),
    .we    (part_wr),
    .waddr (widx[TE_AW-1:0]),
    .wdata ({entry_offset, entry_size}),
    .re    (accept),
    .raddr (ridx[TE_AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      pvalid  <= '0;
      for (int d = 0; d < DISK_COUNT; d++) begin
        geo_secs[d] <= '0;
        geo_hds[d]  <= '0;
        geo_cyls[d] <= '0;
      end
    end else begin
      if (accept) begin
        a_valid <= 1'b1;
      end else if (push) begin
        a_valid <= 1'b0;
      end
      if (part_wr) begin
        pvalid[widx[TE_AW-1:0]] <= 1'b1;
      end
      // A zero in any geometry field marks the disk absent.
      if (geo_wr) begin
        geo_secs[geo_idx] <= geo_absent ? '0 : geo_sectors;
        geo_hds[geo_idx]  <= geo_absent ? '0 : h_clamp;
        geo_cyls[geo_idx] <= geo_absent ? '0 : geo_cylinders;
      end
    end
  end

  // Tables are sampled at the accept edge so every request sees all earlier writes.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_op       <= operation;
      a_blk      <= block_number;
      a_is_write <= is_write;
      a_unit     <= unit;
      a_unit_ok  <= unit_ok;
      a_prange   <= 7'(minor_number[PART_IDX_W-1:0]) < 7'(TABLE_ENTRIES);
      a_pvalid   <= pvalid[ridx[TE_AW-1:0]];
      a_secs     <= unit_ok ? geo_secs[unit_sel] : '0;
      a_heads    <= unit_ok ? geo_hds[unit_sel]  : '0;
      a_cyl      <= unit_ok ? geo_cyls[unit_sel] : '0;
    end
  end

  always_comb begin
    psize = (a_prange && a_pvalid) ? rdata[ABS_W-1:0]       : '0;
    poff  = (a_prange && a_pvalid) ? rdata[2*ABS_W-1:ABS_W] : '0;
    sum   = {1'b0, a_blk} + {1'b0, poff};

    push_beat.go       = 1'b0;
    push_beat.status   = ST_OK;
    push_beat.abs_blk  = sum[ABS_W-1:0];
    push_beat.secs     = a_secs;
    push_beat.heads    = a_heads;
    push_beat.cyl      = a_cyl;
    push_beat.unit_lo  = a_unit[1:0];
    push_beat.is_write = a_is_write;

    // Checks in priority order; the disk size check finishes in the back end.
    if (a_op == OP_TRANSLATE) begin
      if (a_blk >= psize) begin
        push_beat.status = ST_RANGE;
      end else if (!a_unit_ok) begin
        push_beat.status = ST_NODEV;
      end else if (sum[ABS_W] || (a_secs == '0)) begin
        push_beat.status = ST_IO;
      end else begin
        push_beat.go = 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/plct_fifo.sv @@
// Short queue between the classifying front end and the divider back end.
`timescale 1ns / 1ps
`include "partition_lba_to_chs_translator_macros.svh"
module plct_fifo import plct_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  beat_t push_beat,
  output logic  full,
  input  logic  pop,
  output beat_t head,
  output logic  empty
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  beat_t         slots [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = count == CW'(FIFO_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_beat;
    end
  end

  `PLCT_ASSERT_NEXT(a_fifo_fill, clk, rst, push && !pop, count == $past(count) + CW'(1), "fifo count did not advance on push")
  `PLCT_ASSERT_NOW(a_fifo_bound, clk, rst, 1'b1, count <= CW'(FIFO_DEPTH), "fifo count above depth")

endmodule

@@ hw/rtl/plct_back.sv @@
// Back end: pipelined sector and head dividers, disk size check, output register.
`timescale 1ns / 1ps
`include "partition_lba_to_chs_translator_macros.svh"
module plct_back import plct_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  output logic                  pop,
  input  beat_t                 head,
  input  logic                  empty,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic [1:0]            status,
  output logic [CYL_W-1:0]      cylinder,
  output logic [HEAD_OUT_W-1:0] head_num,
  output logic [SEC_W-1:0]      sector,
  output logic                  controller,
  output logic                  drive,
  output logic [CMD_W-1:0]      command
);

  typedef struct packed {
    logic              go;
    logic [1:0]        status;
    logic [ABS_W-1:0]  num;
    logic [SEC_W-1:0]  rem1;
    logic [HEAD_W-1:0] rem2;
    logic [SEC_W-1:0]  secs;
    logic [HEAD_W-1:0] heads;
    logic [CYL_W-1:0]  cyl;
    logic [1:0]        unit_lo;
    logic              is_write;
  } stage_t;

  logic                  adv;
  logic [PIPE_STAGES-1:0] pv;
  stage_t                pipe [PIPE_STAGES];
  stage_t                nxt  [PIPE_STAGES];
  stage_t                entry;
  stage_t                last;
  logic                  ok;

  // The whole pipe moves whenever the output register is free or being drained.
  assign adv = !rsp_valid || !rsp_stall;
  assign pop = adv && !empty;

  always_comb begin
    entry.go       = head.go;
    entry.status   = head.status;
    entry.num      = head.abs_blk;
    entry.rem1     = '0;
    entry.rem2     = '0;
    entry.secs     = head.secs;
    entry.heads    = head.heads;
    entry.cyl      = head.cyl;
    entry.unit_lo  = head.unit_lo;
    entry.is_write = head.is_write;
  end

  for (genvar g = 0; g < PIPE_STAGES; g++) begin : g_stage
    stage_t          s_in;
    stage_t          st;
    logic [SEC_W:0]  r1x;
    logic [HEAD_W:0] r2x;

    if (g == 0) begin : g_first
      assign s_in = entry;
    end else begin : g_rest
      assign s_in = pipe[g-1];
    end

    // Restoring division, DIV_BITS quotient bits per stage; the quotient shifts
    // into num. First half divides by sectors, second half by heads.
    always_comb begin
      st  = s_in;
      r1x = '0;
      r2x = '0;
      for (int k = 0; k < DIV_BITS; k++) begin
        if (g < DIV_STAGES) begin
          r1x    = {st.rem1, st.num[ABS_W-1]};
          st.num = {st.num[ABS_W-2:0], 1'b0};
          if (r1x >= {1'b0, st.secs}) begin
            r1x       = r1x - {1'b0, st.secs};
            st.num[0] = 1'b1;
          end
          st.rem1 = r1x[SEC_W-1:0];
        end else begin
          r2x    = {st.rem2, st.num[ABS_W-1]};
          st.num = {st.num[ABS_W-2:0], 1'b0};
          if (r2x >= {1'b0, st.heads}) begin
            r2x       = r2x - {1'b0, st.heads};
            st.num[0] = 1'b1;
          end
          st.rem2 = r2x[HEAD_W-1:0];
        end
      end
      nxt[g] = st;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pipe[g] <= nxt[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv        <= '0;
      rsp_valid <= 1'b0;
    end else if (adv) begin
      pv        <= {pv[PIPE_STAGES-2:0], !empty};
      rsp_valid <= pv[PIPE_STAGES-1];
    end
  end

  // Block lies on the disk iff its cylinder quotient is below the cylinder count.
  assign last = pipe[PIPE_STAGES-1];
  assign ok   = last.go && (last.num < ABS_W'(last.cyl));

  always_ff @(posedge clk) begin
    if (adv) begin
      status     <= last.go ? (ok ? ST_OK : ST_IO) : last.status;
      cylinder   <= ok ? last.num[CYL_W-1:0] : '0;
      head_num   <= ok ? last.rem2[HEAD_OUT_W-1:0] : '0;
      sector     <= ok ? last.rem1 + SEC_W'(1) : '0;
      controller <= ok ? last.unit_lo[1] : 1'b0;
      drive      <= ok ? last.unit_lo[0] : 1'b0;
      command    <= ok ? (last.is_write ? CMD_WR : CMD_RD) : '0;
    end
  end

  `PLCT_ASSERT_NEXT(a_back_hold, clk, rst, rsp_valid && rsp_stall, $stable(pv), "divider pipe moved while output stalled")
  `PLCT_ASSERT_NOW(a_back_sector, clk, rst, rsp_valid && status == ST_OK && command != '0, sector != '0, "translated beat with zero sector")

endmodule

@@ hw/rtl/partition_lba_to_chs_translator.sv @@
// A request passes the table read and classify register, the queue, 16 divider stages
//   and the output register; the 32-bit dividers are fully pipelined.
// Throughput: one request per cycle, held back only while the response side stalls.
// A 4-entry queue decouples the front end from the divider pipe.
// Reset (sync, active high) empties the pipe and queue and zeroes the partition
//   valid bits and disk geometries at once; no clearing pass is needed.
`timescale 1ns / 1ps
module partition_lba_to_chs_translator import plct_pkg::*; #(
  parameter int DISK_COUNT    = DISK_COUNT_DEF,
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic [1:0]            operation,
  input  logic [MINOR_W-1:0]    minor_number,
  input  logic [ABS_W-1:0]      block_number,
  input  logic                  is_write,
  input  logic [IDX_W-1:0]      table_index,
  input  logic [ABS_W-1:0]      entry_offset,
  input  logic [ABS_W-1:0]      entry_size,
  input  logic [SEC_W-1:0]      geo_sectors,
  input  logic [HEAD_W-1:0]     geo_heads,
  input  logic [CYL_W-1:0]      geo_cylinders,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic [1:0]            status,
  output logic [CYL_W-1:0]      cylinder,
  output logic [HEAD_OUT_W-1:0] head,
  output logic [SEC_W-1:0]      sector,
  output logic                  controller,
  output logic                  drive,
  output logic [CMD_W-1:0]      command
);

  logic  push;
  beat_t push_beat;
  logic  q_full;
  logic  q_pop;
  beat_t q_head;
  logic  q_empty;

  plct_front #(
    .DISK_COUNT    (DISK_COUNT),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .operation     (operation),
    .minor_number  (minor_number),
    .block_number  (block_number),
    .is_write      (is_write),
    .table_index   (table_index),
    .entry_offset  (entry_offset),
    .entry_size    (entry_size),
    .geo_sectors   (geo_sectors),
    .geo_heads     (geo_heads),
    .geo_cylinders (geo_cylinders),
    .push          (push),
    .push_beat     (push_beat),
    .q_full        (q_full)
  );

  plct_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_beat (push_beat),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  plct_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .status     (status),
    .cylinder   (cylinder),
    .head_num   (head),
    .sector     (sector),
    .controller (controller),
    .drive      (drive),
    .command    (command)
  );

endmodule

@@ bench/partition_chs_check.sv @@
// Checker for the block-to-CHS translator: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module partition_chs_check import plct_pkg::*; #(
  parameter int DISKS   = DISK_COUNT_DEF,
  parameter int ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_stall,
  input  logic [1:0]            operation,
  input  logic [MINOR_W-1:0]    minor_number,
  input  logic [ABS_W-1:0]      block_number,
  input  logic                  is_write,
  input  logic [IDX_W-1:0]      table_index,
  input  logic [ABS_W-1:0]      entry_offset,
  input  logic [ABS_W-1:0]      entry_size,
  input  logic [SEC_W-1:0]      geo_sectors,
  input  logic [HEAD_W-1:0]     geo_heads,
  input  logic [CYL_W-1:0]      geo_cylinders,
  input  logic                  rsp_valid,
  input  logic                  rsp_stall,
  input  logic [1:0]            status,
  input  logic [CYL_W-1:0]      cylinder,
  input  logic [HEAD_OUT_W-1:0] head,
  input  logic [SEC_W-1:0]      sector,
  input  logic                  controller,
  input  logic                  drive,
  input  logic [CMD_W-1:0]      command,
  output int                    fail_count,
  output int                    outstanding
);

  typedef struct packed {
    logic [1:0]            status;
    logic [CYL_W-1:0]      cylinder;
    logic [HEAD_OUT_W-1:0] head;
    logic [SEC_W-1:0]      sector;
    logic                  controller;
    logic                  drive;
    logic [CMD_W-1:0]      command;
  } chs_result_t;

  logic [ABS_W-1:0]  part_base [ENTRIES];
  logic [ABS_W-1:0]  part_len  [ENTRIES];
  logic [SEC_W-1:0]  disk_secs [DISKS];
  logic [HEAD_W-1:0] disk_heads[DISKS];
  logic [ABS_W-1:0]  disk_span [DISKS];

  chs_result_t pending_chs[$];
  int          mismatches = 0;

  assign fail_count = mismatches;

  initial outstanding = 0;

  // Apply one request beat to the shadow tables and return the translation it yields.
  function automatic chs_result_t apply_request(
    logic [1:0] op, logic [MINOR_W-1:0] minor, logic [ABS_W-1:0] blk, logic wr,
    logic [IDX_W-1:0] idx, logic [ABS_W-1:0] off, logic [ABS_W-1:0] len,
    logic [SEC_W-1:0] secs_in, logic [HEAD_W-1:0] heads_in, logic [CYL_W-1:0] cyls_in);
    chs_result_t       r;
    logic [ABS_W-1:0]  p_len;
    logic [ABS_W-1:0]  p_base;
    logic [UNIT_W-1:0] unit;
    logic [ABS_W:0]    abs_sum;
    logic [ABS_W-1:0]  track;
    logic [HEAD_W-1:0] h;
    int                u;
    r = '0;
    case (op)
      OP_TRANSLATE: begin
        p_len = '0;
        p_base = '0;
        if (int'(minor[4:0]) < ENTRIES) begin
          p_len = part_len[minor[4:0]];
          p_base = part_base[minor[4:0]];
        end
        unit = UNIT_W'(minor >> PART_SHIFT);
        u = int'(unit);
        abs_sum = {1'b0, blk} + {1'b0, p_base};
        if (blk >= p_len) begin
          r.status = ST_RANGE;
        end else if (u >= DISKS) begin
          r.status = ST_NODEV;
        end else if (abs_sum[ABS_W] || abs_sum[ABS_W-1:0] >= disk_span[u] ||
                     disk_secs[u] == '0 || disk_heads[u] == '0) begin
          r.status = ST_IO;
        end else begin
          track = abs_sum[ABS_W-1:0] / ABS_W'(disk_secs[u]);
          r.status = ST_OK;
          r.sector = SEC_W'((abs_sum[ABS_W-1:0] % ABS_W'(disk_secs[u])) + 1);
          r.head = HEAD_OUT_W'(track % ABS_W'(disk_heads[u]));
          r.cylinder = CYL_W'(track / ABS_W'(disk_heads[u]));
          r.controller = unit[1];
          r.drive = unit[0];
          r.command = wr ? CMD_WR : CMD_RD;
        end
      end
      OP_PART_WRITE: begin
        if (int'(idx) < ENTRIES) begin
          part_base[idx] = off;
          part_len[idx] = len;
        end
      end
      OP_GEO_WRITE: begin
        if (int'(idx) < DISKS) begin
          h = (heads_in > MAX_HEADS) ? MAX_HEADS : heads_in;
          if (secs_in == '0 || h == '0 || cyls_in == '0) begin
            disk_secs[idx] = '0;
            disk_heads[idx] = '0;
            disk_span[idx] = '0;
          end else begin
            disk_secs[idx] = secs_in;
            disk_heads[idx] = h;
            disk_span[idx] = ABS_W'(cyls_in) * ABS_W'(h) * ABS_W'(secs_in);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    chs_result_t want;
    if (rst) begin
      pending_chs.delete();
      for (int i = 0; i < ENTRIES; i++) begin
        part_base[i] = '0;
        part_len[i] = '0;
      end
      for (int i = 0; i < DISKS; i++) begin
        disk_secs[i] = '0;
        disk_heads[i] = '0;
        disk_span[i] = '0;
      end
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (pending_chs.size() == 0) begin
          $error("response beat with nothing outstanding (status 0x%0h)", status);
          mismatches++;
        end else begin
          want = pending_chs.pop_front();
          check_field("status", 32'(want.status), 32'(status));
          check_field("cylinder", 32'(want.cylinder), 32'(cylinder));
          check_field("head", 32'(want.head), 32'(head));
          check_field("sector", 32'(want.sector), 32'(sector));
          check_field("controller", 32'(want.controller), 32'(controller));
          check_field("drive", 32'(want.drive), 32'(drive));
          check_field("command", 32'(want.command), 32'(command));
        end
      end
      // Responses are in order, so the shadow tables advance in request order.
      if (req_valid && !req_stall) begin
        pending_chs.push_back(apply_request(operation, minor_number, block_number, is_write,
                                            table_index, entry_offset, entry_size,
                                            geo_sectors, geo_heads, geo_cylinders));
      end
    end
    outstanding <= pending_chs.size();
  end

endmodule

@@ bench/tb_partition_lba_to_chs_translator.sv @@
// Testbench top: drives request beats and response stalls, and reports the verdict.
`timescale 1ns / 1ps
module tb_partition_lba_to_chs_translator import plct_pkg::*;;

  localparam int RANDOM_ITEMS = 550;
  localparam int LIMIT        = 200000;
  localparam int TAIL         = 40;
  localparam int HOLD_FROM    = 300;
  localparam int HOLD_LEN     = 200;
  localparam int CALM_FROM    = 800;
  localparam int CALM_LEN     = 300;

  typedef struct packed {
    logic [1:0]         op;
    logic [MINOR_W-1:0] minor;
    logic [ABS_W-1:0]   blk;
    logic               wr;
    logic [IDX_W-1:0]   idx;
    logic [ABS_W-1:0]   off;
    logic [ABS_W-1:0]   len;
    logic [SEC_W-1:0]   secs;
    logic [HEAD_W-1:0]  heads;
    logic [CYL_W-1:0]   cyls;
  } req_item_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  logic [1:0]            operation = '0;
  logic [MINOR_W-1:0]    minor_number = '0;
  logic [ABS_W-1:0]      block_number = '0;
  logic                  is_write = 1'b0;
  logic [IDX_W-1:0]      table_index = '0;
  logic [ABS_W-1:0]      entry_offset = '0;
  logic [ABS_W-1:0]      entry_size = '0;
  logic [SEC_W-1:0]      geo_sectors = '0;
  logic [HEAD_W-1:0]     geo_heads = '0;
  logic [CYL_W-1:0]      geo_cylinders = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  logic [1:0]            status;
  logic [CYL_W-1:0]      cylinder;
  logic [HEAD_OUT_W-1:0] head;
  logic [SEC_W-1:0]      sector;
  logic                  controller;
  logic                  drive;
  logic [CMD_W-1:0]      command;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int rsp_cycle = 0;

  // What has been written so far, used only to steer blocks into partitions and disks.
  logic [ABS_W-1:0] span_hint[DISK_COUNT_DEF]    = '{default: '0};
  logic [ABS_W-1:0] len_hint [TABLE_ENTRIES_DEF] = '{default: '0};

  partition_lba_to_chs_translator i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .operation(operation), .minor_number(minor_number), .block_number(block_number),
    .is_write(is_write), .table_index(table_index), .entry_offset(entry_offset),
    .entry_size(entry_size), .geo_sectors(geo_sectors), .geo_heads(geo_heads),
    .geo_cylinders(geo_cylinders),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .status(status), .cylinder(cylinder), .head(head), .sector(sector),
    .controller(controller), .drive(drive), .command(command)
  );

  partition_chs_check i_chs_check (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .operation(operation), .minor_number(minor_number), .block_number(block_number),
    .is_write(is_write), .table_index(table_index), .entry_offset(entry_offset),
    .entry_size(entry_size), .geo_sectors(geo_sectors), .geo_heads(geo_heads),
    .geo_cylinders(geo_cylinders),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .status(status), .cylinder(cylinder), .head(head), .sector(sector),
    .controller(controller), .drive(drive), .command(command),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold to back the pipe up, then a quiet stretch.
  always @(posedge clk) begin
    rsp_cycle <= rsp_cycle + 1;
    if (rsp_cycle >= HOLD_FROM && rsp_cycle < HOLD_FROM + HOLD_LEN)
      rsp_stall <= 1'b1;
    else if (rsp_cycle >= CALM_FROM && rsp_cycle < CALM_FROM + CALM_LEN)
      rsp_stall <= 1'b0;
    else
      rsp_stall <= ($urandom_range(0, 99) < 37);
  end

  function automatic req_item_t noise_item();
    req_item_t r;
    r.op = 2'($urandom);
    r.minor = MINOR_W'($urandom);
    r.blk = $urandom;
    r.wr = 1'($urandom);
    r.idx = IDX_W'($urandom);
    r.off = $urandom;
    r.len = $urandom;
    r.secs = SEC_W'($urandom);
    r.heads = HEAD_W'($urandom);
    r.cyls = CYL_W'($urandom);
    return r;
  endfunction

  function automatic req_item_t geo_item(int unsigned d, int unsigned s, int unsigned h,
                                         int unsigned c);
    req_item_t   r;
    int unsigned hc;
    r = noise_item();
    r.op = OP_GEO_WRITE;
    r.idx = IDX_W'(d);
    r.secs = SEC_W'(s);
    r.heads = HEAD_W'(h);
    r.cyls = CYL_W'(c);
    hc = (h > 16) ? 16 : h;
    if (d < DISK_COUNT_DEF)
      span_hint[d] = (s == 0 || hc == 0 || c == 0) ? '0 : ABS_W'(c * hc * s);
    return r;
  endfunction

  function automatic req_item_t part_item(int unsigned idx, logic [ABS_W-1:0] off,
                                          logic [ABS_W-1:0] len);
    req_item_t r;
    r = noise_item();
    r.op = OP_PART_WRITE;
    r.idx = IDX_W'(idx);
    r.off = off;
    r.len = len;
    if (idx < TABLE_ENTRIES_DEF) len_hint[idx] = len;
    return r;
  endfunction

  function automatic req_item_t xlate_item(int unsigned minor, logic [ABS_W-1:0] blk,
                                           logic wr);
    req_item_t r;
    r = noise_item();
    r.op = OP_TRANSLATE;
    r.minor = MINOR_W'(minor);
    r.blk = blk;
    r.wr = wr;
    return r;
  endfunction

  // Offer one beat; hold it until accepted. Gaps are decided before valid rises.
  task automatic offer(input req_item_t r, input bit calm);
    while (!calm && $urandom_range(0, 99) < 37) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    operation <= r.op;
    minor_number <= r.minor;
    block_number <= r.blk;
    is_write <= r.wr;
    table_index <= r.idx;
    entry_offset <= r.off;
    entry_size <= r.len;
    geo_sectors <= r.secs;
    geo_heads <= r.heads;
    geo_cylinders <= r.cyls;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  initial begin : stimulus
    req_item_t        item;
    req_item_t        unused_op;
    int unsigned      pick, d, s, h, c, idx, m, sel;
    logic [ABS_W-1:0] span, off, len;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty tables, table extremes, each error in check order, CHS corners.
    offer(xlate_item(0, 0, 1'b0), 1'b0);
    unused_op = noise_item();
    unused_op.op = 2'd3;
    offer(unused_op, 1'b0);
    offer(geo_item(0, 63, 16, 1024), 1'b0);
    offer(geo_item(1, 255, 31, 65535), 1'b0);
    offer(geo_item(2, 0, 4, 100), 1'b0);
    offer(geo_item(3, 1, 1, 1), 1'b0);
    offer(geo_item(31, 255, 31, 65535), 1'b0);
    offer(part_item(0, '0, '1), 1'b0);
    offer(part_item(8, '1, '1), 1'b0);
    offer(part_item(9, '0, '1), 1'b0);
    offer(part_item(16, '0, 100), 1'b0);
    offer(part_item(24, '0, 5), 1'b0);
    offer(part_item(31, '0, 10), 1'b0);
    offer(xlate_item(0, 0, 1'b0), 1'b0);
    offer(xlate_item(0, 1032191, 1'b1), 1'b0);
    offer(xlate_item(0, 1032192, 1'b0), 1'b0);
    offer(xlate_item(9, 32'd267382799, 1'b1), 1'b0);
    offer(xlate_item(8, 0, 1'b0), 1'b0);
    offer(xlate_item(8, 1, 1'b1), 1'b0);
    offer(xlate_item(16, 5, 1'b0), 1'b0);
    offer(xlate_item(24, 0, 1'b1), 1'b0);
    offer(xlate_item(24, 1, 1'b0), 1'b0);
    offer(xlate_item(255, 3, 1'b0), 1'b0);
    offer(xlate_item(255, 10, 1'b1), 1'b0);
    offer(xlate_item(8'h28, 0, 1'b0), 1'b0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        d = $urandom_range(0, 5);
        s = $urandom_range(1, 255);
        h = $urandom_range(1, 31);
        c = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 64) : $urandom_range(1, 65535);
        case ($urandom_range(0, 9))
          0: s = 0;
          1: h = 0;
          2: c = 0;
          default: ;
        endcase
        item = geo_item(d, s, h, c);
      end else if (pick < 15) begin
        idx = $urandom_range(0, 31);
        span = span_hint[idx >> 3];
        if (span != '0 && $urandom_range(0, 99) < 85) begin
          off = $urandom_range(0, span - 1);
          len = $urandom_range(1, span - off);
        end else begin
          off = $urandom;
          len = $urandom;
        end
        item = part_item(idx, off, len);
      end else if (pick < 18) begin
        item = noise_item();
        item.op = 2'd3;
      end else begin
        m = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 31) : $urandom_range(0, 255);
        len = len_hint[m & 31];
        sel = $urandom_range(0, 9);
        if (len != '0 && sel < 8)
          item = xlate_item(m, $urandom_range(0, len - 1), 1'($urandom));
        else if (sel == 8)
          item = xlate_item(m, len, 1'($urandom));
        else
          item = xlate_item(m, $urandom, 1'($urandom));
      end
      offer(item, n >= 100 && n < 260);
    end
    req_valid <= 1'b0;

    // Let the last accepted beat reach the checker before polling what is left.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
